### rtl/utf16_newline_converter_macros.svh
// Assertion macros for the UTF-16 newline converter.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef UTF16_NEWLINE_CONVERTER_MACROS_SVH
`define UTF16_NEWLINE_CONVERTER_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define U16NL_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define U16NL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define U16NL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/u16nl_pkg.sv
// ----------------------------------------------------------------------------
// u16nl_pkg
// Types, codes and helpers shared by the UTF-16 newline converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u16nl_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Result queue geometry; one item makes at most MAX_RES results.
	localparam int MAX_RES = 2;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QCW     = $clog2(QDEPTH + 1);

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 2;

	typedef enum logic [1:0] {
		FMT_UNIX = 2'd0,
		FMT_MAC  = 2'd1,
		FMT_WIN  = 2'd2
	} fmt_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_SOURCE_FORMAT = 2'd0,
		REG_TARGET_FORMAT = 2'd1,
		REG_SWAP_ENABLE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0] source_format;
		logic [1:0] target_format;
		logic       swap_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
	} unit_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		unit_t unit;
		logic  last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} push_t;

	typedef struct packed {
		logic fire;
		logic stream_end;
		logic have_held;
	} core_status_t;

	typedef struct packed {
		logic [QCW-1:0] count;
	} q_status_t;

	// Newline character in the given byte order; big puts the zero byte first.
	function automatic unit_t make_nl(input logic [7:0] ch, input logic big);
		unit_t u;
		u.byte_first  = big ? 8'h00 : ch;
		u.byte_second = big ? ch : 8'h00;
		return u;
	endfunction

	function automatic unit_t make_data(input logic [7:0] b0, input logic [7:0] b1,
			input logic sw);
		unit_t u;
		u.byte_first  = sw ? b1 : b0;
		u.byte_second = sw ? b0 : b1;
		return u;
	endfunction

endpackage

`default_nettype wire

### rtl/u16nl_unit_if.sv
// ----------------------------------------------------------------------------
// u16nl_unit_if
// Input channel: one UTF-16 code unit per item, with an end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface u16nl_unit_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte_first;
	logic [7:0] in_byte_second;
	logic       stream_end;

	modport source(output valid, output in_byte_first, output in_byte_second,
		output stream_end, input ready);
	modport sink(input valid, input in_byte_first, input in_byte_second,
		input stream_end, output ready);
endinterface

`default_nettype wire

### rtl/u16nl_result_if.sv
// ----------------------------------------------------------------------------
// u16nl_result_if
// Output channel: one emitted code unit per item, last marks end of a run.
// ----------------------------------------------------------------------------
`default_nettype none

interface u16nl_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte_first;
	logic [7:0] out_byte_second;
	logic       last_of_run;

	modport source(output valid, output out_byte_first, output out_byte_second,
		output last_of_run, input ready);
	modport sink(input valid, input out_byte_first, input out_byte_second,
		input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/u16nl_cfg_if.sv
// ----------------------------------------------------------------------------
// u16nl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface u16nl_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [u16nl_pkg::CFG_IW-1:0] index;
	logic [u16nl_pkg::CFG_DW-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/u16nl_cfg_regs.sv
// ----------------------------------------------------------------------------
// u16nl_cfg_regs
// Format and swap registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module u16nl_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_valid,
	output logic                              wr_ready,
	input  wire logic [u16nl_pkg::CFG_IW-1:0] wr_index,
	input  wire logic [u16nl_pkg::CFG_DW-1:0] wr_data,
	output u16nl_pkg::cfg_t                   settings
);
	import u16nl_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign settings = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_valid) begin
			case (cfg_reg_t'(wr_index))
				REG_SOURCE_FORMAT: cfg_q.source_format <= wr_data[1:0];
				REG_TARGET_FORMAT: cfg_q.target_format <= wr_data[1:0];
				REG_SWAP_ENABLE:   cfg_q.swap_enable   <= wr_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/u16nl_core.sv
// ----------------------------------------------------------------------------
// u16nl_core
// Input register, newline conversion logic and the held-unit state.
// ----------------------------------------------------------------------------
`default_nettype none

module u16nl_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire u16nl_pkg::item_t      item,
	input  wire u16nl_pkg::cfg_t       settings,
	input  wire logic                  room,
	output u16nl_pkg::push_t           push,
	output u16nl_pkg::core_status_t    status
);
	import u16nl_pkg::*;

	logic        valid_s1;
	item_t       item_s1;

	logic [15:0] held_q;
	logic        have_q;
	logic        skip_q;

	logic [15:0] held_next;
	logic        have_next;
	logic        skip_next;

	logic        fire;
	logic        copy_mode;
	logic [7:0]  src_ch;
	logic [7:0]  tgt_ch;
	logic        is_nl;
	logic        big;
	logic [15:0] cur;
	logic        pair;
	logic        skip_mid;
	logic        emit_a;
	logic        emit_b;
	unit_t       data_cur;
	unit_t       data_held;
	unit_t       unit_a;
	unit_t       u0;
	unit_t       u1;
	logic [1:0]  cnt;

	assign fire       = valid_s1 && room;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign cur       = {item_s1.byte_first, item_s1.byte_second};
	assign copy_mode = (settings.source_format == settings.target_format) ||
		(settings.source_format == 2'd3) || (settings.target_format == 2'd3);
	assign src_ch    = (fmt_t'(settings.source_format) == FMT_UNIX) ? CH_LF : CH_CR;
	assign tgt_ch    = (fmt_t'(settings.target_format) == FMT_UNIX) ? CH_LF : CH_CR;
	assign is_nl     = (item_s1.byte_first == src_ch && item_s1.byte_second == 8'h00) ||
		(item_s1.byte_first == 8'h00 && item_s1.byte_second == src_ch);
	// The byte order of a newline follows the unit that carries it.
	assign big       = (item_s1.byte_first == 8'h00) != settings.swap_enable;
	assign data_cur  = make_data(item_s1.byte_first, item_s1.byte_second,
		settings.swap_enable);
	assign data_held = make_data(held_q[15:8], held_q[7:0], settings.swap_enable);

	// A CR LF pair counts only when both units share one byte order.
	assign pair     = (cur == {CH_LF, 8'h00} && held_q == {CH_CR, 8'h00}) ||
		(cur == {8'h00, CH_LF} && held_q == {8'h00, CH_CR});
	assign skip_mid = have_q ? pair : skip_q;
	assign emit_a   = have_q && (pair || !skip_q);
	assign emit_b   = item_s1.stream_end && !skip_mid;
	assign unit_a   = pair ? make_nl(tgt_ch, big) : data_held;

	always_comb begin
		u0        = data_cur;
		u1        = data_cur;
		cnt       = 2'd1;
		held_next = held_q;
		have_next = have_q;
		skip_next = skip_q;
		if (copy_mode) begin
			u0  = data_cur;
			cnt = 2'd1;
		end else if (fmt_t'(settings.source_format) != FMT_WIN) begin
			if (is_nl) begin
				if (fmt_t'(settings.target_format) == FMT_WIN) begin
					u0  = make_nl(CH_CR, big);
					u1  = make_nl(CH_LF, big);
					cnt = 2'd2;
				end else begin
					u0  = make_nl(tgt_ch, big);
					cnt = 2'd1;
				end
			end else begin
				u0  = data_cur;
				cnt = 2'd1;
			end
		end else begin
			if (emit_a) begin
				u0  = unit_a;
				u1  = data_cur;
				cnt = emit_b ? 2'd2 : 2'd1;
			end else begin
				u0  = data_cur;
				cnt = emit_b ? 2'd1 : 2'd0;
			end
			held_next = cur;
			have_next = 1'b1;
			skip_next = skip_mid;
		end
		if (item_s1.stream_end) begin
			have_next = 1'b0;
			skip_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			have_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (fire) begin
			held_q <= held_next;
			have_q <= have_next;
			skip_q <= skip_next;
		end
	end

	assign push.count     = fire ? cnt : 2'd0;
	assign push.res0.unit = u0;
	assign push.res0.last = (cnt == 2'd1);
	assign push.res1.unit = u1;
	assign push.res1.last = 1'b1;

	assign status.fire       = fire;
	assign status.stream_end = item_s1.stream_end;
	assign status.have_held  = have_q;

endmodule

`default_nettype wire

### rtl/u16nl_outq.sv
// ----------------------------------------------------------------------------
// u16nl_outq
// Small result queue; takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module u16nl_outq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire u16nl_pkg::push_t      push,
	output logic                       room,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output u16nl_pkg::result_t         res,
	output u16nl_pkg::q_status_t       status
);
	import u16nl_pkg::*;

	result_t        mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;
	logic           pop;
	logic [QAW-1:0] wr_plus1;

	assign res_valid = (count_q != '0);
	assign res       = mem[rd_q];
	assign pop       = res_valid && res_ready;
	assign wr_plus1  = wr_q + QAW'(1);
	// Room is judged on the stored count alone, so ready does not depend on
	// the downstream handshake.
	assign room      = count_q <= QCW'(QDEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem[wr_plus1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(push.count);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + QCW'(push.count) - QCW'(pop);
		end
	end

	assign status.count = count_q;

endmodule

`default_nettype wire

### rtl/utf16_newline_converter.sv
// ----------------------------------------------------------------------------
// utf16_newline_converter
// Converts UTF-16 line endings between LF, CR and CR LF, with byte swapping.
// ----------------------------------------------------------------------------
// Channel      Role   Handshake     Carries
// code_units   sink   valid/ready   in_byte_first, in_byte_second, stream_end
// results      source valid/ready   out_byte_first, out_byte_second, last_of_run
// cfg          sink   valid/ready   index, data (always ready)
//
// An item enters the input register and is converted from there; its zero to two
// results are written into a four-entry result queue. While results are taken,
// one item a cycle is taken as long as each makes at most one result; the queue's
// single read port sets the rate at one result a cycle otherwise.
// Reset clears the format registers, the held unit and the queue.
// A stalled output fills the queue; input ready drops once the input register
// holds an item and fewer than two queue entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16_newline_converter_macros.svh"

module utf16_newline_converter (
	input  wire logic      clk,
	input  wire logic      arst_n,
	u16nl_unit_if.sink     code_units,
	u16nl_result_if.source results,
	u16nl_cfg_if.sink      cfg
);
	import u16nl_pkg::*;

	cfg_t         settings;
	item_t        item;
	logic         room;
	push_t        core_push;
	core_status_t core_status;
	q_status_t    q_status;
	result_t      res;
	logic [3:0]   fill_after_push;
	logic         end_fire;

	assign item.byte_first  = code_units.in_byte_first;
	assign item.byte_second = code_units.in_byte_second;
	assign item.stream_end  = code_units.stream_end;

	u16nl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.settings (settings)
	);

	u16nl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (code_units.valid),
		.item_ready (code_units.ready),
		.item       (item),
		.settings   (settings),
		.room       (room),
		.push       (core_push),
		.status     (core_status)
	);

	u16nl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_push),
		.room      (room),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.res       (res),
		.status    (q_status)
	);

	assign results.out_byte_first  = res.unit.byte_first;
	assign results.out_byte_second = res.unit.byte_second;
	assign results.last_of_run     = res.last;

	assign fill_after_push = 4'(q_status.count) + 4'(core_push.count);
	assign end_fire        = core_status.fire && core_status.stream_end;

	`U16NL_ASSERT_ALWAYS(a_queue_bound, q_status.count <= QCW'(QDEPTH), "result queue over depth")
	`U16NL_ASSERT_SAME(a_no_overflow, core_status.fire, fill_after_push <= 4'(QDEPTH), "queue overflow")
	`U16NL_ASSERT_NEXT(a_end_clears, end_fire, !core_status.have_held, "held unit survives end of text")

endmodule

`default_nettype wire
